@@ rtl/clcsm_pkg.sv @@
package clcsm_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BLOCK  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_STRING = 3'd3,
        MODE_CHAR   = 3'd4,
        MODE_CLOSE  = 3'd5
    } mode_t;

    localparam logic [2:0] CODE_NONE      = 3'd0;
    localparam logic [2:0] CODE_CMT_BEGIN = 3'd1;
    localparam logic [2:0] CODE_CMT_END   = 3'd2;
    localparam logic [2:0] CODE_STR_BEGIN = 3'd3;
    localparam logic [2:0] CODE_STR_END   = 3'd4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    typedef struct packed {
        mode_t mode;
        logic  esc;
    } lex_state_t;

    typedef struct packed {
        logic [2:0] code;
        logic       last;
    } result_t;

    // up to two results per input transaction, in order
    typedef struct packed {
        logic    first_vld;
        result_t first;
        logic    second_vld;
        result_t second;
    } push_t;

    typedef struct packed {
        lex_state_t st;
        logic [2:0] code;
    } classify_t;

    // anchor of byte b; nx is the following byte on the same line when !eol
    function automatic classify_t classify(lex_state_t st, logic [7:0] b, logic eol,
                                           logic [7:0] nx);
        classify_t r;
        r.st   = st;
        r.code = CODE_NONE;
        if (st.esc) begin
            r.st.esc = 1'b0;
        end else begin
            case (st.mode)
                MODE_BLOCK: begin
                    if (b == CH_STAR && !eol && nx == CH_SLASH) r.st.mode = MODE_CLOSE;
                end
                MODE_CLOSE: begin
                    r.code    = CODE_CMT_END;
                    r.st.mode = MODE_NORMAL;
                end
                MODE_LINE: begin
                end
                MODE_STRING: begin
                    if (b == CH_BSLASH && !eol) begin
                        r.st.esc = 1'b1;
                    end else if (b == CH_DQUOTE) begin
                        r.code    = CODE_STR_END;
                        r.st.mode = MODE_NORMAL;
                    end
                end
                MODE_CHAR: begin
                    if (b == CH_BSLASH && !eol) begin
                        r.st.esc = 1'b1;
                    end else if (b == CH_SQUOTE) begin
                        r.st.mode = MODE_NORMAL;
                    end
                end
                default: begin
                    r.st.mode = MODE_NORMAL;
                    if (b == CH_SLASH && !eol && nx == CH_STAR) begin
                        r.code    = CODE_CMT_BEGIN;
                        r.st.mode = MODE_BLOCK;
                        r.st.esc  = 1'b1;   // swallow the star of the opener
                    end else if (b == CH_SLASH && !eol && nx == CH_SLASH) begin
                        r.st.mode = MODE_LINE;
                    end else if (b == CH_SQUOTE) begin
                        r.st.mode = MODE_CHAR;
                    end else if (b == CH_DQUOTE) begin
                        r.code    = CODE_STR_BEGIN;
                        r.st.mode = MODE_STRING;
                    end
                end
            endcase
        end
        if (eol) begin
            if (r.st.mode == MODE_LINE || r.st.mode == MODE_CHAR) r.st.mode = MODE_NORMAL;
            r.st.esc = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/clike_comment_string_marker_top.sv @@
// Channel | Direction | tdata                          | tlast       | tuser
// s_      | in        | [7:0] char_byte                | end_of_line | -
// m_      | out       | [2:0] anchor_code, [7:3] zero  | line_done   | -
//
// One byte in, one anchor out per cycle unless stalled. Anchors come out one byte
// late; a line-ending byte releases up to two anchors, which drain via a 4-entry
// output queue. s_tready drops only while the queue has fewer than two free entries.
// Reset (synchronous, active low) returns to normal text mode with nothing held.
module clike_comment_string_marker_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] anchor_code, [7:3] zero
    output logic       m_tlast
);

    clcsm_pkg::lex_state_t st_reg, st_next;
    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    clcsm_pkg::classify_t  r_held, r_new;
    clcsm_pkg::lex_state_t st_mid;
    clcsm_pkg::push_t      push;
    clcsm_pkg::result_t    out_data;
    logic                  accept;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        r_held = clcsm_pkg::classify(st_reg, held_byte_reg, 1'b0, s_tdata);
        st_mid = held_valid_reg ? r_held.st : st_reg;
        r_new  = clcsm_pkg::classify(st_mid, s_tdata, 1'b1, 8'h00);

        push.first_vld   = accept && held_valid_reg;
        push.first.code  = r_held.code;
        push.first.last  = 1'b0;
        push.second_vld  = accept && s_tlast;
        push.second.code = r_new.code;
        push.second.last = 1'b1;

        st_next         = st_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            st_next         = s_tlast ? r_new.st : st_mid;
            held_byte_next  = s_tdata;
            held_valid_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode    <= clcsm_pkg::MODE_NORMAL;
            st_reg.esc     <= 1'b0;
            held_valid_reg <= 1'b0;
        end else begin
            st_reg         <= st_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_byte_reg <= held_byte_next;
    end

    clcsm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {5'b00000, out_data.code};
    assign m_tlast = out_data.last;

endmodule

@@ rtl/clcsm_fifo.sv @@
module clcsm_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  clcsm_pkg::push_t   push,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output clcsm_pkg::result_t out_data
);

    localparam int PW = clcsm_pkg::FIFO_PTR_W;

    clcsm_pkg::result_t mem_reg [clcsm_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic [PW-1:0] wr_idx2;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case pair of results
    assign space_ok  = (count_reg <= (PW+1)'(clcsm_pkg::FIFO_DEPTH - 2));

    always_comb begin
        wr_idx2     = wr_ptr_reg + PW'(push.first_vld);
        wr_ptr_next = wr_ptr_reg + PW'(push.first_vld) + PW'(push.second_vld);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push.first_vld) + (PW+1)'(push.second_vld)
                      - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.first_vld) mem_reg[wr_ptr_reg] <= push.first;
        if (push.second_vld) mem_reg[wr_idx2] <= push.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/clcsm_checker.sv @@
module clcsm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("tdata padding not zero");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("anchor code out of range");

    a_eol_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("line end transaction left no result pending");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind clike_comment_string_marker_top clcsm_checker u_clcsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ verif/clike_comment_string_marker_top_tb.sv @@
`timescale 1ns / 100ps

module clike_comment_string_marker_top_tb;

    typedef struct {
        logic [2:0] code;
        logic       last;
    } anchor_t;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
        bit         typed;
        int         n;
        logic [2:0] c0;
        logic [2:0] c1;
    } text_row_t;

    localparam int N_ROWS = 28;
    localparam int PHASE_ITEMS = 374;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    anchor_t    anchor_q [$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         sender_idle = 0;
    int         recv_idle = 0;

    // typed expectation for the transaction currently offered
    bit         cur_typed = 1'b0;
    int         cur_n = 0;
    logic [2:0] cur_c0 = clcsm_pkg::CODE_NONE;
    logic [2:0] cur_c1 = clcsm_pkg::CODE_NONE;

    // lexer state of the predictor
    clcsm_pkg::mode_t lex_mode = clcsm_pkg::MODE_NORMAL;
    logic       lex_esc = 1'b0;
    logic [7:0] held_ch = 8'h00;
    logic       held_ok = 1'b0;

    text_row_t  text_rows [N_ROWS];

    clike_comment_string_marker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("MISMATCH @%0t: %s got 0x%02h expected 0x%02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // anchor of byte b; nx is the next byte on the same line when !eol
    function automatic logic [2:0] mark_byte(logic [7:0] b, logic eol, logic [7:0] nx);
        logic [2:0] code;
        code = clcsm_pkg::CODE_NONE;
        if (lex_esc) begin
            lex_esc = 1'b0;
        end else begin
            case (lex_mode)
                clcsm_pkg::MODE_BLOCK: begin
                    if (b == clcsm_pkg::CH_STAR && !eol && nx == clcsm_pkg::CH_SLASH) begin
                        lex_mode = clcsm_pkg::MODE_CLOSE;
                    end
                end
                clcsm_pkg::MODE_CLOSE: begin
                    code = clcsm_pkg::CODE_CMT_END;
                    lex_mode = clcsm_pkg::MODE_NORMAL;
                end
                clcsm_pkg::MODE_LINE: begin
                end
                clcsm_pkg::MODE_STRING: begin
                    if (b == clcsm_pkg::CH_BSLASH && !eol) begin
                        lex_esc = 1'b1;
                    end else if (b == clcsm_pkg::CH_DQUOTE) begin
                        code = clcsm_pkg::CODE_STR_END;
                        lex_mode = clcsm_pkg::MODE_NORMAL;
                    end
                end
                clcsm_pkg::MODE_CHAR: begin
                    if (b == clcsm_pkg::CH_BSLASH && !eol) begin
                        lex_esc = 1'b1;
                    end else if (b == clcsm_pkg::CH_SQUOTE) begin
                        lex_mode = clcsm_pkg::MODE_NORMAL;
                    end
                end
                default: begin
                    lex_mode = clcsm_pkg::MODE_NORMAL;
                    if (b == clcsm_pkg::CH_SLASH && !eol && nx == clcsm_pkg::CH_STAR) begin
                        code = clcsm_pkg::CODE_CMT_BEGIN;
                        lex_mode = clcsm_pkg::MODE_BLOCK;
                        lex_esc = 1'b1;
                    end else if (b == clcsm_pkg::CH_SLASH && !eol &&
                                 nx == clcsm_pkg::CH_SLASH) begin
                        lex_mode = clcsm_pkg::MODE_LINE;
                    end else if (b == clcsm_pkg::CH_SQUOTE) begin
                        lex_mode = clcsm_pkg::MODE_CHAR;
                    end else if (b == clcsm_pkg::CH_DQUOTE) begin
                        code = clcsm_pkg::CODE_STR_BEGIN;
                        lex_mode = clcsm_pkg::MODE_STRING;
                    end
                end
            endcase
        end
        if (eol) begin
            if (lex_mode == clcsm_pkg::MODE_LINE || lex_mode == clcsm_pkg::MODE_CHAR) begin
                lex_mode = clcsm_pkg::MODE_NORMAL;
            end
            lex_esc = 1'b0;
        end
        return code;
    endfunction

    // runs on every accepted input transaction
    task automatic take_byte();
        anchor_t got [2];
        int      n;
        n = 0;
        if (held_ok) begin
            got[n].code = mark_byte(held_ch, 1'b0, s_tdata);
            got[n].last = 1'b0;
            n++;
        end
        if (s_tlast) begin
            got[n].code = mark_byte(s_tdata, 1'b1, 8'h00);
            got[n].last = 1'b1;
            n++;
            held_ok = 1'b0;
            held_ch = 8'h00;
        end else begin
            held_ch = s_tdata;
            held_ok = 1'b1;
        end
        if (cur_typed) begin
            // a single anchor ends the line only when no byte was held
            if (cur_n == 1) anchor_q.push_back('{cur_c0, s_tlast});
            if (cur_n == 2) begin
                anchor_q.push_back('{cur_c0, 1'b0});
                anchor_q.push_back('{cur_c1, 1'b1});
            end
        end else begin
            for (int k = 0; k < n; k++) anchor_q.push_back(got[k]);
        end
    endtask

    always @(posedge aclk) begin
        anchor_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) take_byte();
            if (m_tvalid && m_tready) begin
                if (anchor_q.size() == 0) begin
                    note_mismatch("unexpected anchor", m_tdata, 8'h00);
                end else begin
                    want = anchor_q.pop_front();
                    if (m_tdata !== {5'b0, want.code})
                        note_mismatch("anchor_code", m_tdata, {5'b0, want.code});
                    if (m_tlast !== want.last)
                        note_mismatch("line_done", {7'b0, m_tlast}, {7'b0, want.last});
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] ch, input logic eol, input bit typed,
                             input int n, input logic [2:0] c0, input logic [2:0] c1);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        cur_typed = typed;
        cur_n = n;
        cur_c0 = c0;
        cur_c1 = c1;
        s_tdata <= ch;
        s_tlast <= eol;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 15) return clcsm_pkg::CH_SLASH;
        if (r < 27) return clcsm_pkg::CH_STAR;
        if (r < 35) return clcsm_pkg::CH_BSLASH;
        if (r < 47) return clcsm_pkg::CH_DQUOTE;
        if (r < 55) return clcsm_pkg::CH_SQUOTE;
        if (r < 70) return 8'($urandom_range(255));
        return 8'($urandom_range(32, 126));
    endfunction

    // mostly text-like lines; some lines are raw noise with random line ends
    task automatic send_text_line();
        int         len;
        bit         noisy;
        logic [7:0] ch;
        logic       eol;
        noisy = ($urandom_range(9) == 0);
        len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            ch = noisy ? 8'($urandom_range(255)) : pick_char();
            eol = noisy ? ($urandom_range(3) == 0) : (k == len - 1);
            send_byte(ch, eol, 1'b0, 0, clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE);
        end
    endtask

    initial begin
        int target;
        text_rows = '{
            // lone byte after reset
            '{8'h61, 1'b1, 1'b1, 1, clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{8'h00, 1'b0, 1'b1, 0, clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{8'hFF, 1'b1, 1'b1, 2, clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b0, 1'b1, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_STAR, 1'b0, 1'b1, 1,
              clcsm_pkg::CODE_CMT_BEGIN, clcsm_pkg::CODE_NONE},
            // opener star swallowed
            '{clcsm_pkg::CH_SLASH, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_STAR, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b0, 1'b1, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_BSLASH, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // escaped quote
            '{clcsm_pkg::CH_DQUOTE, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b0, 1'b1, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // backslash at line end
            '{clcsm_pkg::CH_BSLASH, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SQUOTE, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // char constant close
            '{clcsm_pkg::CH_SQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // string over lines
            '{clcsm_pkg::CH_DQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_DQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // inside line comment
            '{clcsm_pkg::CH_DQUOTE, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_STAR, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            // star-slash split by eol
            '{clcsm_pkg::CH_STAR, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_STAR, 1'b0, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE},
            '{clcsm_pkg::CH_SLASH, 1'b1, 1'b0, 0,
              clcsm_pkg::CODE_NONE, clcsm_pkg::CODE_NONE}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle = 19;
        recv_idle = 49;
        foreach (text_rows[i])
            send_byte(text_rows[i].ch, text_rows[i].eol, text_rows[i].typed,
                      text_rows[i].n, text_rows[i].c0, text_rows[i].c1);

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = (ph == 0) ? 19 : (ph == 1) ? 49 : 0;
            recv_idle = (ph == 0) ? 49 : (ph == 1) ? 19 : 0;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_text_line();
        end
        s_tvalid <= 1'b0;

        for (int w = 0; w < 20000 && anchor_q.size() != 0; w++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (anchor_q.size() != 0) begin
            $display("MISMATCH: %0d anchors never arrived", anchor_q.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/clcsm_pkg.sv
rtl/clcsm_fifo.sv
rtl/clike_comment_string_marker_top.sv
rtl/clcsm_checker.sv
verif/clike_comment_string_marker_top_tb.sv
